FILE: design/aps_pkg.sv
// Package for armor_pair_scoring: fixed-point constants, the arctangent table
// and the configuration register codes. It has no dependencies.
`default_nettype none
package aps_pkg;

  localparam int CORDIC_STAGES_DEF = 16;
  localparam int ATAN_LEN          = 24;
  localparam int QUOT_W            = 16;

  localparam logic [14:0] PI_Q13      = 15'd25736;
  localparam logic [14:0] HALF_PI_Q13 = 15'd12868;
  localparam logic signed [33:0] PI_Q30 = 34'sd3373259426;
  localparam logic [16:0] ONE_Q15     = 17'd32768;

  localparam logic [15:0] WEIGHT_BASE_RST  = 16'd9830;
  localparam logic [15:0] WEIGHT_SLOPE_RST = 16'd13107;
  localparam logic [15:0] WEIGHT_MIN_RST   = 16'd9830;
  localparam logic [15:0] WEIGHT_MAX_RST   = 16'd22938;

  typedef enum logic [1:0] {
    CFG_WEIGHT_BASE  = 2'd0,
    CFG_WEIGHT_SLOPE = 2'd1,
    CFG_WEIGHT_MIN   = 2'd2,
    CFG_WEIGHT_MAX   = 2'd3
  } cfg_idx_t;

  // atan(2^-i) in Q2.30
  function automatic logic [33:0] atan_q30(input int unsigned i);
    logic [33:0] a;
    case (i)
      0: a = 34'd843314857;
      1: a = 34'd497837830;
      2: a = 34'd263043837;
      3: a = 34'd133525159;
      4: a = 34'd67021687;
      5: a = 34'd33543516;
      6: a = 34'd16775852;
      7: a = 34'd8388438;
      8: a = 34'd4194283;
      9: a = 34'd2097149;
      10: a = 34'd1048576;
      11: a = 34'd524288;
      12: a = 34'd262144;
      13: a = 34'd131072;
      14: a = 34'd65536;
      15: a = 34'd32768;
      16: a = 34'd16384;
      17: a = 34'd8192;
      18: a = 34'd4096;
      19: a = 34'd2048;
      20: a = 34'd1024;
      21: a = 34'd512;
      22: a = 34'd256;
      23: a = 34'd128;
      default: a = 34'd0;
    endcase
    return a;
  endfunction

endpackage
`default_nettype wire

FILE: design/armor_pair_scoring.sv
// armor_pair_scoring: scores a pair of light bars per beat.
// A beat travels from the accepting edge to out_tvalid through the root and divider chains.
// Throughput: one beat per cycle; the whole pipeline stalls while a result waits.
// Reset (synchronous, rst_n low) clears valid bits and loads weight register defaults.
// Uses aps_pkg, aps_div and aps_cordic.
`default_nettype none
module armor_pair_scoring #(
  parameter int CORDIC_STAGES = aps_pkg::CORDIC_STAGES_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // left_x, left_y, left_angle, left_length, right_x, right_y, right_angle,
  // right_length, 2 pad bits
  input  wire logic [127:0] in_tdata,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // mid_x, mid_y, spacing_ratio, length_ratio, rect_error
  output logic [79:0]       out_tdata,
  // divide_fault
  output logic [0:0]        out_tuser,
  input  wire logic         cfg_we,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [15:0]  cfg_wdata
);
  localparam int NS  = (CORDIC_STAGES > aps_pkg::ATAN_LEN) ? aps_pkg::ATAN_LEN
                                                            : CORDIC_STAGES;
  localparam int LAT = 50;
  localparam int PD  = 44 - NS;

  logic ce;
  logic [LAT:0] v_r;

  assign ce        = out_tready | ~v_r[LAT];
  assign in_tready = ce;

  // config registers
  logic [15:0] base_r, slope_r, wmin_r, wmax_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r  <= aps_pkg::WEIGHT_BASE_RST;
      slope_r <= aps_pkg::WEIGHT_SLOPE_RST;
      wmin_r  <= aps_pkg::WEIGHT_MIN_RST;
      wmax_r  <= aps_pkg::WEIGHT_MAX_RST;
    end else if (cfg_we) begin
      case (aps_pkg::cfg_idx_t'(cfg_index))
        aps_pkg::CFG_WEIGHT_BASE:  base_r  <= cfg_wdata;
        aps_pkg::CFG_WEIGHT_SLOPE: slope_r <= cfg_wdata;
        aps_pkg::CFG_WEIGHT_MIN:   wmin_r  <= cfg_wdata;
        aps_pkg::CFG_WEIGHT_MAX:   wmax_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (ce) begin
      v_r <= {v_r[LAT-1:0], in_tvalid};
    end
  end

  // input fields
  logic [15:0] lx, ly, ll, rx, ry, rl;
  logic [14:0] la, ra;
  assign lx = in_tdata[15:0];
  assign ly = in_tdata[31:16];
  assign la = in_tdata[46:32];
  assign ll = in_tdata[62:47];
  assign rx = in_tdata[78:63];
  assign ry = in_tdata[94:79];
  assign ra = in_tdata[109:95];
  assign rl = in_tdata[125:110];

  // stage 0
  logic signed [16:0] dx_r, dy_r;
  logic [16:0] sum_r;
  logic [15:0] lmax_r, lmin_r;
  logic [14:0] pdiff_r, la_r, ra_r;
  logic [32:0] pass_r;
  logic [16:0] smx, smy;
  assign smx = {1'b0, lx} + {1'b0, rx};
  assign smy = {1'b0, ly} + {1'b0, ry};

  always_ff @(posedge clk) begin
    if (ce) begin
      dx_r    <= $signed({1'b0, rx}) - $signed({1'b0, lx});
      dy_r    <= $signed({1'b0, ry}) - $signed({1'b0, ly});
      sum_r   <= {1'b0, ll} + {1'b0, rl};
      lmax_r  <= (ll > rl) ? ll : rl;
      lmin_r  <= (ll > rl) ? rl : ll;
      pdiff_r <= (la >= ra) ? la - ra : ra - la;
      la_r    <= la;
      ra_r    <= ra;
      pass_r  <= {(ll == '0) || (rl == '0), smy[16:1], smx[16:1]};
    end
  end

  // parallelism error, stage 1
  logic [14:0] p1;
  logic [13:0] par_r;
  logic [14:0] par_full;
  assign p1       = (pdiff_r >= aps_pkg::PI_Q13) ? pdiff_r - aps_pkg::PI_Q13 : pdiff_r;
  assign par_full = (p1 > aps_pkg::HALF_PI_Q13) ? aps_pkg::PI_Q13 - p1 : p1;
  always_ff @(posedge clk) begin
    if (ce) par_r <= par_full[13:0];
  end

  // squared distance, stages 1-2
  logic signed [33:0] sqx_r, sqy_r;
  logic [33:0] d2_r;
  always_ff @(posedge clk) begin
    if (ce) begin
      sqx_r <= dx_r * dx_r;
      sqy_r <= dy_r * dy_r;
      d2_r  <= 34'($unsigned(sqx_r) + $unsigned(sqy_r));
    end
  end

  // integer root of d2 << 18, one result bit per stage (stages 3-28)
  logic [26:0] sq_rem_r  [27];
  logic [25:0] sq_root_r [27];
  logic [33:0] sq_d2_r   [27];
  assign sq_rem_r[0]  = '0;
  assign sq_root_r[0] = '0;
  assign sq_d2_r[0]   = d2_r;

  for (genvar k = 0; k < 26; k++) begin : g_sqrt
    logic [51:0] rad;
    logic [28:0] rs, tr;
    logic        ge;
    assign rad = {sq_d2_r[k], 18'b0};
    assign rs  = {sq_rem_r[k], rad[51-2*k -: 2]};
    assign tr  = {1'b0, sq_root_r[k], 2'b01};
    assign ge  = rs >= tr;
    always_ff @(posedge clk) begin
      if (ce) begin
        sq_rem_r[k+1]  <= ge ? 27'(rs - tr) : 27'(rs);
        sq_root_r[k+1] <= {sq_root_r[k][24:0], ge};
        sq_d2_r[k+1]   <= sq_d2_r[k];
      end
    end
  end

  logic [16:0] sum_d_r [28];
  always_ff @(posedge clk) begin
    if (ce) begin
      sum_d_r[0] <= sum_r;
      for (int i = 1; i < 28; i++) sum_d_r[i] <= sum_d_r[i-1];
    end
  end

  // spacing ratio, stages 29-45
  logic [15:0] spacing;
  aps_div #(.DW(26), .VW(17)) u_div_spc (
    .clk    (clk),
    .ce     (ce),
    .dend_i (sq_root_r[26]),
    .dsor_i (sum_d_r[27]),
    .quot_o (spacing)
  );

  // length ratio, stages 1-17
  logic [15:0] lratio;
  aps_div #(.DW(24), .VW(16)) u_div_len (
    .clk    (clk),
    .ce     (ce),
    .dend_i ({lmax_r, 8'b0}),
    .dsor_i (lmin_r),
    .quot_o (lratio)
  );

  // roll angle, stages 1..NS+1
  logic signed [33:0] cz;
  logic               czero;
  aps_cordic #(.NS(NS)) u_cordic (
    .clk    (clk),
    .ce     (ce),
    .dx_i   (dx_r),
    .dy_i   (dy_r),
    .z_o    (cz),
    .zero_o (czero)
  );

  logic [14:0] la_d_r [NS+1];
  logic [14:0] ra_d_r [NS+1];
  always_ff @(posedge clk) begin
    if (ce) begin
      la_d_r[0] <= la_r;
      ra_d_r[0] <= ra_r;
      for (int i = 1; i <= NS; i++) begin
        la_d_r[i] <= la_d_r[i-1];
        ra_d_r[i] <= ra_d_r[i-1];
      end
    end
  end

  // rounding to Q3.13, then bar deviations
  logic signed [33:0] zr;
  logic signed [16:0] roll_r;
  logic [14:0] la_e_r, ra_e_r;
  logic signed [18:0] el, er;
  logic [17:0] el_r, er_r, perp_r;
  assign zr = cz + 34'sd65536;
  assign el = $signed({4'b0, la_e_r}) - 19'(roll_r) - 19'sd12868;
  assign er = $signed({4'b0, ra_e_r}) - 19'(roll_r) - 19'sd12868;

  always_ff @(posedge clk) begin
    if (ce) begin
      roll_r <= czero ? '0 : zr[33:17];
      la_e_r <= la_d_r[NS];
      ra_e_r <= ra_d_r[NS];
      el_r   <= el[18] ? 18'(-el) : el[17:0];
      er_r   <= er[18] ? 18'(-er) : er[17:0];
      perp_r <= (el_r > er_r) ? el_r : er_r;
    end
  end

  // alignment lines
  logic [13:0] par_d_r  [47];
  logic [17:0] perp_d_r [PD];
  logic [15:0] lrat_d_r [32];
  logic [32:0] pass_d_r [49];
  logic [15:0] spc_d_r  [4];
  always_ff @(posedge clk) begin
    if (ce) begin
      par_d_r[0]  <= par_r;
      perp_d_r[0] <= perp_r;
      lrat_d_r[0] <= lratio;
      pass_d_r[0] <= pass_r;
      spc_d_r[0]  <= spacing;
      for (int i = 1; i < 47; i++) par_d_r[i] <= par_d_r[i-1];
      for (int i = 1; i < PD; i++) perp_d_r[i] <= perp_d_r[i-1];
      for (int i = 1; i < 32; i++) lrat_d_r[i] <= lrat_d_r[i-1];
      for (int i = 1; i < 49; i++) pass_d_r[i] <= pass_d_r[i-1];
      for (int i = 1; i < 4; i++)  spc_d_r[i]  <= spc_d_r[i-1];
    end
  end

  // weight, stages 46-48
  logic [31:0] prod_r;
  logic [24:0] wsum_r;
  logic [24:0] wa, wb;
  logic [15:0] w_r;
  assign wa = (wsum_r < 25'(wmin_r)) ? 25'(wmin_r) : wsum_r;
  assign wb = (wa > 25'(wmax_r)) ? 25'(wmax_r) : wa;
  always_ff @(posedge clk) begin
    if (ce) begin
      prod_r <= slope_r * spacing;
      wsum_r <= 25'(base_r) + 25'(prod_r[31:8]);
      w_r    <= (wb > 25'(aps_pkg::ONE_Q15)) ? 16'(aps_pkg::ONE_Q15) : wb[15:0];
    end
  end

  // mix, stages 49-50
  logic [16:0] wc;
  logic [29:0] m1_r;
  logic [34:0] m2_r;
  logic [34:0] msum;
  logic [19:0] err;
  assign wc   = aps_pkg::ONE_Q15 - {1'b0, w_r};
  assign msum = 35'(m1_r) + m2_r;
  assign err  = msum[34:15];

  logic [79:0] odata_r;
  logic        ofault_r;
  always_ff @(posedge clk) begin
    if (ce) begin
      m1_r     <= w_r * par_d_r[46];
      m2_r     <= wc * perp_d_r[PD-1];
      odata_r  <= {(err > 20'hFFFF) ? 16'hFFFF : err[15:0], lrat_d_r[31],
                   spc_d_r[3], pass_d_r[48][31:0]};
      ofault_r <= pass_d_r[48][32];
    end
  end

  assign out_tvalid   = v_r[LAT];
  assign out_tdata    = odata_r;
  assign out_tuser[0] = ofault_r;

  a_fault_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |->
      (out_tdata[47:32] == 16'hFFFF) || (out_tdata[63:48] == 16'hFFFF))
    else $error("fault without saturated ratio");

  a_weight_range: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[48] |-> ({1'b0, w_r} <= aps_pkg::ONE_Q15))
    else $error("weight above one");

  a_par_fold: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[1] |-> ({1'b0, par_r} <= aps_pkg::HALF_PI_Q13))
    else $error("parallelism error not folded");

endmodule
`default_nettype wire

FILE: design/aps_div.sv
// Pipelined restoring divider with 16-bit saturating quotient, one bit per stage.
// Depends on aps_pkg for the quotient width.
`default_nettype none
module aps_div #(
  parameter int DW = 24,
  parameter int VW = 16
) (
  input  wire logic                       clk,
  input  wire logic                       ce,
  input  wire logic [DW-1:0]              dend_i,
  input  wire logic [VW-1:0]              dsor_i,
  output logic [aps_pkg::QUOT_W-1:0]      quot_o
);
  localparam int QW = aps_pkg::QUOT_W;
  localparam int CW = (DW > VW + QW) ? DW : VW + QW;

  logic [VW:0]    rem_r  [QW+1];
  logic [QW-1:0]  low_r  [QW+1];
  logic [VW-1:0]  dsor_r [QW+1];
  logic [QW-1:0]  q_r    [QW+1];
  logic           sat_r  [QW+1];

  // quotient overflows 16 bits (or divisor is zero)
  always_ff @(posedge clk) begin
    if (ce) begin
      sat_r[0]  <= CW'(dend_i) >= CW'({dsor_i, {QW{1'b0}}});
      rem_r[0]  <= (VW+1)'(dend_i[DW-1:QW]);
      low_r[0]  <= dend_i[QW-1:0];
      dsor_r[0] <= dsor_i;
      q_r[0]    <= '0;
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [VW:0] tmp;
    logic        ge;
    assign tmp = {rem_r[k][VW-1:0], low_r[k][QW-1-k]};
    assign ge  = tmp >= {1'b0, dsor_r[k]};
    always_ff @(posedge clk) begin
      if (ce) begin
        rem_r[k+1]  <= ge ? tmp - {1'b0, dsor_r[k]} : tmp;
        q_r[k+1]    <= {q_r[k][QW-2:0], ge};
        low_r[k+1]  <= low_r[k];
        dsor_r[k+1] <= dsor_r[k];
        sat_r[k+1]  <= sat_r[k];
      end
    end
  end

  assign quot_o = sat_r[QW] ? '1 : q_r[QW];

endmodule
`default_nettype wire

FILE: design/aps_cordic.sv
// Pipelined vectoring CORDIC: atan2(dy, dx) in Q2.30, one rotation per stage.
// Depends on aps_pkg for the arctangent table and pi.
`default_nettype none
module aps_cordic #(
  parameter int NS = aps_pkg::CORDIC_STAGES_DEF
) (
  input  wire logic               clk,
  input  wire logic               ce,
  input  wire logic signed [16:0] dx_i,
  input  wire logic signed [16:0] dy_i,
  output logic signed [33:0]      z_o,
  output logic                    zero_o
);
  logic signed [33:0] x_r [NS+1];
  logic signed [33:0] y_r [NS+1];
  logic signed [33:0] z_r [NS+1];
  logic               zero_r [NS+1];

  logic signed [33:0] dxe, dye;
  assign dxe = 34'(dx_i);
  assign dye = 34'(dy_i);

  // fold left half-plane into right half-plane
  always_ff @(posedge clk) begin
    if (ce) begin
      zero_r[0] <= (dx_i == '0) && (dy_i == '0);
      if (dx_i < 0) begin
        x_r[0] <= (-dxe) <<< 14;
        y_r[0] <= (-dye) <<< 14;
        z_r[0] <= (dy_i >= 0) ? aps_pkg::PI_Q30 : -aps_pkg::PI_Q30;
      end else begin
        x_r[0] <= dxe <<< 14;
        y_r[0] <= dye <<< 14;
        z_r[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < NS; i++) begin : g_rot
    logic signed [33:0] ang;
    assign ang = $signed(aps_pkg::atan_q30(i));
    always_ff @(posedge clk) begin
      if (ce) begin
        zero_r[i+1] <= zero_r[i];
        if (y_r[i] > 0) begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + ang;
        end else begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - ang;
        end
      end
    end
  end

  assign z_o    = z_r[NS];
  assign zero_o = zero_r[NS];

endmodule
`default_nettype wire

FILE: tb/tb_armor_pair_scoring.sv
// Testbench for armor_pair_scoring: directed table then random bar pairs under four
// idle/stall mixes and several weight settings, each beat checked against a local scorer
// or a typed expectation. Depends on aps_pkg and the armor_pair_scoring RTL.
`timescale 1ns / 100ps
`default_nettype none
module tb_armor_pair_scoring;

  typedef struct {
    logic [15:0] lx, ly, ll, rx, ry, rl;
    logic [14:0] la, ra;
  } bar_pair_t;

  typedef struct packed {
    logic [15:0] mid_x, mid_y, spacing, lratio, rect;
    logic        fault;
  } score_t;

  typedef struct {
    bar_pair_t pair;
    bit        typed;
    score_t    want;
  } row_t;

  localparam int IDLE_LIMIT = 4000;

  logic         clk, rst_n;
  logic         in_tvalid, in_tready;
  logic [127:0] in_tdata;
  logic         out_tvalid, out_tready;
  logic [79:0]  out_tdata;
  logic [0:0]   out_tuser;
  logic         cfg_we;
  logic [1:0]   cfg_index;
  logic [15:0]  cfg_wdata;

  armor_pair_scoring i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  longint w_base, w_slope, w_min, w_max;
  score_t pending_scores[$];
  int     errors;
  int     snd_pct, rcv_pct;
  int     quiet_cycles;

  const longint ATAN_TAB[24] = '{
    843314857, 497837830, 263043837, 133525159, 67021687, 33543516,
    16775852, 8388438, 4194283, 2097149, 1048576, 524288,
    262144, 131072, 65536, 32768, 16384, 8192, 4096, 2048,
    1024, 512, 256, 128};

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic longint roll_of(longint dx, longint dy);
    longint x, y, z, xs, ys;
    int     n;
    z = 0;
    if (dx == 0 && dy == 0) return 0;
    if (dx < 0) begin
      x = -dx;
      y = -dy;
      z = (dy >= 0) ? 64'sd3373259426 : -64'sd3373259426;
    end else begin
      x = dx;
      y = dy;
    end
    x = x * 16384;
    y = y * 16384;
    n = (aps_pkg::CORDIC_STAGES_DEF > 24) ? 24 : aps_pkg::CORDIC_STAGES_DEF;
    for (int i = 0; i < n; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x += ys;
        y -= xs;
        z += ATAN_TAB[i];
      end else begin
        x -= ys;
        y += xs;
        z -= ATAN_TAB[i];
      end
    end
    return (z + 65536) >>> 17;
  endfunction

  function automatic longint root_of(longint v);
    longint r, b;
    r = 0;
    b = 64'sd1 <<< 62;
    while (b > v) b = b >>> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >>> 1) + b;
      end else begin
        r = r >>> 1;
      end
      b = b >>> 2;
    end
    return r;
  endfunction

  function automatic score_t score_pair(bar_pair_t p);
    score_t s;
    longint dx, dy, sum, lmax, lmin, spc, lr, par, roll, el, er, perp, w, err;
    longint la, ra;
    bit     flt;
    flt  = 1'b0;
    la   = p.la;
    ra   = p.ra;
    dx   = longint'(p.rx) - longint'(p.lx);
    dy   = longint'(p.ry) - longint'(p.ly);
    sum  = longint'(p.ll) + longint'(p.rl);
    lmax = (p.ll > p.rl) ? p.ll : p.rl;
    lmin = (p.ll > p.rl) ? p.rl : p.ll;
    if (sum == 0) begin
      spc = 65535;
      flt = 1'b1;
    end else begin
      spc = root_of((dx * dx + dy * dy) <<< 18) / sum;
      if (spc > 65535) spc = 65535;
    end
    if (lmin == 0) begin
      lr  = 65535;
      flt = 1'b1;
    end else begin
      lr = (lmax <<< 8) / lmin;
      if (lr > 65535) lr = 65535;
    end
    par = la - ra;
    if (par < 0) par = -par;
    if (par >= aps_pkg::PI_Q13) par -= aps_pkg::PI_Q13;
    if (par > aps_pkg::HALF_PI_Q13) par = aps_pkg::PI_Q13 - par;
    roll = roll_of(dx, dy);
    el = la - roll - aps_pkg::HALF_PI_Q13;
    if (el < 0) el = -el;
    er = ra - roll - aps_pkg::HALF_PI_Q13;
    if (er < 0) er = -er;
    perp = (el > er) ? el : er;
    w = w_base + ((w_slope * spc) >>> 8);
    if (w < w_min) w = w_min;
    if (w > w_max) w = w_max;
    if (w > 32768) w = 32768;
    err = (w * par + (32768 - w) * perp) >>> 15;
    if (err > 65535) err = 65535;
    s.mid_x   = 16'((longint'(p.lx) + p.rx) >>> 1);
    s.mid_y   = 16'((longint'(p.ly) + p.ry) >>> 1);
    s.spacing = 16'(spc);
    s.lratio  = 16'(lr);
    s.rect    = 16'(err);
    s.fault   = flt;
    return s;
  endfunction

  function automatic logic [15:0] clip16(int v);
    return (v < 0) ? 16'd0 : (v > 65535) ? 16'hFFFF : 16'(v);
  endfunction

  function automatic bar_pair_t random_pair();
    bar_pair_t p;
    int k;
    k = $urandom_range(99);
    if (k < 30) begin
      p.lx = 16'($urandom); p.ly = 16'($urandom); p.ll = 16'($urandom);
      p.rx = 16'($urandom); p.ry = 16'($urandom); p.rl = 16'($urandom);
      p.la = 15'($urandom); p.ra = 15'($urandom);
      if (k < 20) begin
        p.la = 15'($urandom_range(25736));
        p.ra = 15'($urandom_range(25736));
      end
    end else begin
      p.lx = 16'($urandom_range(60000));
      p.ly = 16'($urandom_range(65535));
      p.rx = clip16(int'(p.lx) + $urandom_range(8000) - 500);
      p.ry = clip16(int'(p.ly) + $urandom_range(2000) - 1000);
      p.ll = 16'($urandom_range(4000, 100));
      p.rl = clip16(int'(p.ll) + $urandom_range(1000) - 500);
      p.la = 15'(10868 + $urandom_range(4000));
      p.ra = 15'(10868 + $urandom_range(4000));
      if (k < 35) p.ll = 16'd0;
      if (k >= 95) p.rl = 16'd0;
    end
    return p;
  endfunction

  task automatic write_weights(longint b, longint s, longint mn, longint mx);
    logic [15:0]       vals[4];
    aps_pkg::cfg_idx_t idx;
    vals = '{16'(b), 16'(s), 16'(mn), 16'(mx)};
    wait (pending_scores.size() == 0);
    repeat (4) @(posedge clk);
    for (int i = 0; i < 4; i++) begin
      idx = aps_pkg::cfg_idx_t'(i);
      cfg_we    <= 1'b1;
      cfg_index <= idx;
      cfg_wdata <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    w_base = b; w_slope = s; w_min = mn; w_max = mx;
  endtask

  task automatic send_pair(bar_pair_t p, bit typed, score_t want);
    in_tvalid <= 1'b1;
    in_tdata  <= {2'b00, p.rl, p.ra, p.ry, p.rx, p.ll, p.la, p.ly, p.lx};
    do @(posedge clk); while (!in_tready);
    pending_scores.push_back(typed ? want : score_pair(p));
    if ($urandom_range(99) < snd_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
  endtask

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= rcv_pct);
  end

  always @(posedge clk) begin
    score_t want, got;
    if (out_tvalid && out_tready) begin
      got.mid_x   = out_tdata[15:0];
      got.mid_y   = out_tdata[31:16];
      got.spacing = out_tdata[47:32];
      got.lratio  = out_tdata[63:48];
      got.rect    = out_tdata[79:64];
      got.fault   = out_tuser[0];
      if (pending_scores.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat %h/%b", $time, out_tdata, out_tuser);
      end else begin
        want = pending_scores.pop_front();
        if (got != want) begin
          errors++;
          $display("%0t: mismatch exp mid %h,%h spc %h lr %h err %h flt %b", $time,
                   want.mid_x, want.mid_y, want.spacing, want.lratio, want.rect, want.fault);
          $display("%0t:          act mid %h,%h spc %h lr %h err %h flt %b", $time,
                   got.mid_x, got.mid_y, got.spacing, got.lratio, got.rect, got.fault);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("tb_armor_pair_scoring: done, errors");
      $finish;
    end
  end

  function automatic row_t mk_row(int lx, int ly, int la, int ll,
                                  int rx, int ry, int ra, int rl);
    row_t r;
    r.pair = '{lx: 16'(lx), ly: 16'(ly), ll: 16'(ll), rx: 16'(rx),
               ry: 16'(ry), rl: 16'(rl), la: 15'(la), ra: 15'(ra)};
    r.typed = 1'b0;
    r.want  = '{default: '0};
    return r;
  endfunction

  initial begin
    row_t      rows[$];
    row_t      r;
    score_t    nil;
    bar_pair_t p;
    errors = 0; snd_pct = 0; rcv_pct = 0; quiet_cycles = 0;
    nil = '{default: '0};
    rst_n = 1'b0; in_tvalid = 1'b0; in_tdata = '0; out_tready = 1'b0;
    cfg_we = 1'b0; cfg_index = aps_pkg::CFG_WEIGHT_BASE; cfg_wdata = '0;
    w_base = aps_pkg::WEIGHT_BASE_RST; w_slope = aps_pkg::WEIGHT_SLOPE_RST;
    w_min = aps_pkg::WEIGHT_MIN_RST; w_max = aps_pkg::WEIGHT_MAX_RST;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // all zero: both divisors zero, coincident centers
    r = mk_row(0, 0, 0, 0, 0, 0, 0, 0);
    r.typed = 1'b1;
    r.want  = '{mid_x: 16'd0, mid_y: 16'd0, spacing: 16'hFFFF, lratio: 16'hFFFF,
                rect: 16'd3860, fault: 1'b1};
    rows.push_back(r);
    rows.push_back(mk_row(65535, 65535, 32767, 65535, 65535, 65535, 32767, 65535));
    rows.push_back(mk_row(0, 0, 0, 65535, 65535, 65535, 25736, 65535));
    rows.push_back(mk_row(65535, 0, 12868, 1, 0, 65535, 12868, 65535));
    rows.push_back(mk_row(100, 100, 12868, 0, 900, 100, 12868, 800));
    rows.push_back(mk_row(100, 100, 12868, 800, 900, 100, 12868, 0));
    rows.push_back(mk_row(500, 500, 0, 300, 500, 500, 25736, 300));
    rows.push_back(mk_row(800, 200, 12868, 300, 100, 200, 12868, 320));
    rows.push_back(mk_row(800, 200, 12868, 300, 100, 900, 12000, 320));
    rows.push_back(mk_row(800, 900, 12868, 300, 100, 200, 13000, 320));
    rows.push_back(mk_row(100, 900, 25736, 300, 100, 200, 0, 300));
    rows.push_back(mk_row(100, 200, 32767, 300, 600, 200, 16384, 310));
    rows.push_back(mk_row(100, 200, 30000, 300, 600, 200, 1000, 310));
    rows.push_back(mk_row(0, 0, 20000, 1, 65535, 65535, 3000, 1));
    rows.push_back(mk_row(1000, 1000, 6434, 16, 1000, 1016, 19302, 16));
    rows.push_back(mk_row(43690, 21845, 10922, 43690, 21845, 43690, 21845, 21845));
    foreach (rows[i]) send_pair(rows[i].pair, rows[i].typed, rows[i].want);

    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin snd_pct = 0;  rcv_pct = 0;  end
        1: begin snd_pct = 48; rcv_pct = 0;  end
        2: begin snd_pct = 0;  rcv_pct = 48; end
        default: begin snd_pct = 8; rcv_pct = 8; end
      endcase
      in_tvalid <= 1'b0;
      case (ph)
        0: write_weights(0, 0, 0, 0);
        1: write_weights(32768, 32768, 32768, 32768);
        2: write_weights(0, 32768, 20000, 5000);
        3: write_weights(9830, 13107, 9830, 22938);
        4: write_weights(0, 65535 & 32768, 0, 32768);
        default: write_weights($urandom_range(32768), $urandom_range(32768),
                               $urandom_range(32768), $urandom_range(32768));
      endcase
      for (int n = 0; n < 175; n++) begin
        if (ph == 5 && n == 80) begin
          in_tvalid <= 1'b0;
          wait (pending_scores.size() == 0);
          @(posedge clk);
        end
        p = random_pair();
        send_pair(p, 1'b0, nil);
      end
    end
    in_tvalid <= 1'b0;
    wait (pending_scores.size() == 0);
    repeat (60) @(posedge clk);
    if (errors == 0 && pending_scores.size() == 0)
      $display("tb_armor_pair_scoring: done, clean");
    else
      $display("tb_armor_pair_scoring: done, errors");
    $finish;
  end
endmodule
`default_nettype wire
